/* hw/rtl/swfp_pkg.sv */
// Package for the movie body header and tag header parser.
// Holds the parse state and result types, reset constants and helper functions.
// Used by swfp_step and swf_body_header_tag_parser; depends on nothing.
package swfp_pkg;

    localparam int MaxResults = 4;
    localparam int TdataOutW  = 112;

    typedef enum logic [2:0] {
        PhWidth   = 3'd0,
        PhFields  = 3'd1,
        PhRate    = 3'd2,
        PhFrames  = 3'd3,
        PhTagHdr  = 3'd4,
        PhLongLen = 3'd5,
        PhSkip    = 3'd6
    } t_phase;

    localparam logic [2:0] KindRate   = 3'd4;
    localparam logic [2:0] KindFrames = 3'd5;
    localparam logic [2:0] KindTag    = 3'd6;

    localparam logic [5:0] ShortLenEscape = 6'h3F;
    localparam logic [4:0] WidthBits      = 5'd5;

    typedef struct packed {
        t_phase      phase;
        logic [4:0]  rect_width;
        logic [1:0]  field_idx;
        logic [4:0]  bits_left;
        logic [31:0] acc;
        logic [31:0] byte_offset;
        logic [31:0] word;
        logic [2:0]  word_cnt;
        logic [9:0]  pending_code;
        logic [31:0] skip_left;
    } t_state;

    localparam t_state StateReset = '{
        phase:        PhWidth,
        rect_width:   5'd0,
        field_idx:    2'd0,
        bits_left:    WidthBits,
        acc:          32'd0,
        byte_offset:  32'd0,
        word:         32'd0,
        word_cnt:     3'd0,
        pending_code: 10'd0,
        skip_left:    32'd0
    };

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [9:0]         tag_type;
        logic [31:0]        tag_offset;
        logic [31:0]        tag_length;
    } t_result;

    typedef t_result [MaxResults-1:0] t_result_arr;

    function automatic t_result make_result(logic [2:0] kind, logic [31:0] value,
                                            logic [9:0] tag_type, logic [31:0] offs,
                                            logic [31:0] len);
        t_result r;
        r.kind       = kind;
        r.value      = value;
        r.tag_type   = tag_type;
        r.tag_offset = offs;
        r.tag_length = len;
        return r;
    endfunction

    // A rectangle field is negative when its most significant bit is set.
    function automatic logic [31:0] sign_extend(logic [31:0] v, logic [4:0] w);
        logic [31:0] r;
        logic [4:0]  top;
        r   = v;
        top = w - 5'd1;
        if (w != 5'd0 && v[top]) begin
            r = v | (32'hFFFF_FFFF << w);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/swfp_step.sv */
// Combinational next-state and result logic for one body byte.
// Unrolls the eight bit steps of the rectangle reader and handles the byte phases.
// Depends on swfp_pkg.
module swfp_step (
    input  swfp_pkg::t_state      i_state,
    input  logic [7:0]            i_data,
    input  logic                  i_first,
    input  logic [31:0]           i_body_length,
    output swfp_pkg::t_state      o_state,
    output swfp_pkg::t_result_arr o_results,
    output logic [2:0]            o_count
);
    import swfp_pkg::*;

    t_state      s;
    t_result_arr res;
    logic [2:0]  n;
    logic [31:0] w;
    logic [31:0] len;
    logic [9:0]  code;

    always_comb begin
        s    = i_first ? StateReset : i_state;
        res  = '0;
        n    = 3'd0;
        w    = 32'd0;
        len  = 32'd0;
        code = 10'd0;
        if (s.byte_offset < i_body_length) begin
            unique case (s.phase)
                PhWidth, PhFields: begin
                    for (int i = 7; i >= 0; i--) begin
                        if (s.phase == PhWidth || s.phase == PhFields) begin
                            s.acc = {s.acc[30:0], i_data[i[2:0]]};
                            if (s.bits_left != 5'd0) begin
                                s.bits_left = s.bits_left - 5'd1;
                            end
                            if (s.bits_left == 5'd0) begin
                                if (s.phase == PhWidth) begin
                                    s.rect_width = s.acc[4:0];
                                    s.acc        = 32'd0;
                                    s.field_idx  = 2'd0;
                                    s.bits_left  = s.rect_width;
                                    s.phase      = PhFields;
                                    if (s.rect_width == 5'd0) begin
                                        for (int k = 0; k < MaxResults; k++) begin
                                            res[n[1:0]] = make_result(3'(k), 32'd0, 10'd0,
                                                                      32'd0, 32'd0);
                                            n = n + 3'd1;
                                        end
                                        s.field_idx = 2'd3;
                                        s.phase     = PhRate;
                                        s.word      = 32'd0;
                                        s.word_cnt  = 3'd0;
                                    end
                                end else begin
                                    res[n[1:0]] = make_result({1'b0, s.field_idx},
                                                              sign_extend(s.acc, s.rect_width),
                                                              10'd0, 32'd0, 32'd0);
                                    n     = n + 3'd1;
                                    s.acc = 32'd0;
                                    if (s.field_idx == 2'd3) begin
                                        s.phase    = PhRate;
                                        s.word     = 32'd0;
                                        s.word_cnt = 3'd0;
                                    end else begin
                                        s.field_idx = s.field_idx + 2'd1;
                                        s.bits_left = s.rect_width;
                                    end
                                end
                            end
                        end
                    end
                end
                PhRate, PhFrames: begin
                    if (s.word_cnt == 3'd0) begin
                        s.word     = {24'd0, i_data};
                        s.word_cnt = 3'd1;
                    end else begin
                        res[n[1:0]] = make_result((s.phase == PhRate) ? KindRate : KindFrames,
                                                  {16'd0, i_data, s.word[7:0]},
                                                  10'd0, 32'd0, 32'd0);
                        n          = n + 3'd1;
                        s.word     = 32'd0;
                        s.word_cnt = 3'd0;
                        s.phase    = (s.phase == PhRate) ? PhFrames : PhTagHdr;
                    end
                end
                PhTagHdr: begin
                    if (s.word_cnt == 3'd0) begin
                        s.word     = {24'd0, i_data};
                        s.word_cnt = 3'd1;
                    end else begin
                        w    = {16'd0, i_data, s.word[7:0]};
                        code = w[15:6];
                        if (w[5:0] == ShortLenEscape) begin
                            s.pending_code = code;
                            s.word         = 32'd0;
                            s.word_cnt     = 3'd0;
                            s.phase        = PhLongLen;
                        end else begin
                            len         = {26'd0, w[5:0]};
                            res[n[1:0]] = make_result(KindTag, 32'd0, code,
                                                      s.byte_offset + 32'd1, len);
                            n           = n + 3'd1;
                            s.word      = 32'd0;
                            s.word_cnt  = 3'd0;
                            s.skip_left = len;
                            s.phase     = (len != 32'd0) ? PhSkip : PhTagHdr;
                        end
                    end
                end
                PhLongLen: begin
                    s.word     = s.word | ({24'd0, i_data} << {s.word_cnt[1:0], 3'd0});
                    s.word_cnt = s.word_cnt + 3'd1;
                    if (s.word_cnt >= 3'd4) begin
                        len         = s.word;
                        res[n[1:0]] = make_result(KindTag, 32'd0, s.pending_code,
                                                  s.byte_offset + 32'd1, len);
                        n           = n + 3'd1;
                        s.word      = 32'd0;
                        s.word_cnt  = 3'd0;
                        s.skip_left = len;
                        s.phase     = (len != 32'd0) ? PhSkip : PhTagHdr;
                    end
                end
                default: begin
                    if (s.skip_left != 32'd0) begin
                        s.skip_left = s.skip_left - 32'd1;
                    end
                    if (s.skip_left == 32'd0) begin
                        s.phase = PhTagHdr;
                    end
                end
            endcase
            s.byte_offset = s.byte_offset + 32'd1;
        end
        o_state   = s;
        o_results = res;
        o_count   = n;
    end

endmodule

/* hw/rtl/swf_body_header_tag_parser.sv */
// Top level of the movie body header and tag header parser.
// Holds the parse state, the body length register and the result buffer.
// Depends on swfp_pkg and swfp_step.
//
// Body bytes arrive on the s_axis channel, one byte per beat, with tuser set
// on the first byte of a body to restart parsing at offset zero. Results
// leave on the m_axis channel, one per beat, with tlast on the final result
// caused by an input byte. The body length is written on the cfg channel,
// which is always ready; it should be written only while the block is idle.
// Each accepted byte is parsed in the cycle it is accepted: the eight bit
// steps of the rectangle reader and the byte phases are all combinational
// between the state registers and the result buffer. Results appear on the
// output in the cycle after the byte is accepted. A byte that gives zero or
// one result lets the next byte in on the following cycle if the receiver is
// ready, so the block then takes one byte per cycle; a byte that gives more
// results holds the output until they all leave, and the next byte is taken
// in the cycle its last result leaves. A stalled receiver holds the current
// result and blocks new bytes once the buffer would otherwise be overwritten.
// Reset clears the parse state, body length and result count, not the buffer.
module swf_body_header_tag_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // data_byte
    input  logic                           s_axis_tuser,  // first_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // kind, value, tag_type, tag_offset, tag_length, zero fill
    output logic [swfp_pkg::TdataOutW-1:0] m_axis_tdata,
    output logic                           m_axis_tlast   // last_of_run
);
    import swfp_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] r_body_length;
    t_result_arr r_res;
    t_result_arr n_res;
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic [1:0]  r_idx;
    logic [1:0]  n_idx;
    logic [2:0]  step_cnt;
    logic        out_last;
    logic        out_fire;
    logic        in_fire;
    t_result     cur;

    swfp_step u_step (
        .i_state       (r_state),
        .i_data        (s_axis_tdata),
        .i_first       (s_axis_tuser),
        .i_body_length (r_body_length),
        .o_state       (n_state),
        .o_results     (n_res),
        .o_count       (step_cnt)
    );

    assign cur           = r_res[r_idx];
    assign out_last      = (({1'b0, r_idx} + 3'd1) == r_cnt);
    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {3'd0, cur.tag_length, cur.tag_offset, cur.tag_type,
                            cur.value, cur.kind};
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 3'd0) || (out_fire && out_last);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (out_fire) begin
            if (out_last) begin
                n_cnt = 3'd0;
                n_idx = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (in_fire && step_cnt != 3'd0) begin
            n_cnt = step_cnt;
            n_idx = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= StateReset;
            r_body_length <= 32'd0;
            r_cnt         <= 3'd0;
            r_idx         <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
            if (i_cfg_valid) begin
                r_body_length <= i_cfg_data;
            end
            if (in_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && step_cnt != 3'd0) begin
            r_res <= n_res;
        end
    end

endmodule
